// File: sv/llq_pkg.sv
// ---------------------------------------------------------------------------
// llq_pkg
// Shared sizes, codes, types and helpers for the linked list queue manager.
// ---------------------------------------------------------------------------
package llq_pkg;

  // Pool and queue sizes
  localparam int NUM_ENTRIES = 256;
  localparam int NUM_QUEUES  = 4;

  // Field and storage widths
  localparam int ACTION_W = 2;
  localparam int QID_W    = 2;
  localparam int ENTRY_W  = $clog2(NUM_ENTRIES);
  localparam int LINK_W   = ENTRY_W + 1;
  localparam int COUNT_W  = 9;

  // A link or end pointer holding NUM_ENTRIES means "none"
  localparam logic [LINK_W-1:0]  LINK_NONE = LINK_W'(NUM_ENTRIES);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MOVE = 2'd2;

  // Command to the queue table: one queue selected, optional writes
  typedef struct packed {
    logic [QID_W-1:0]  sel;
    logic              top_we;
    logic [LINK_W-1:0] top_wdata;
    logic              bot_we;
    logic [LINK_W-1:0] bot_wdata;
    logic              cnt_inc;
    logic              cnt_dec;
  } qtab_cmd_t;

  // View of the selected queue, with saturated count neighbors
  typedef struct packed {
    logic [LINK_W-1:0]  top;
    logic [LINK_W-1:0]  bottom;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] count_up;
    logic [COUNT_W-1:0] count_dn;
  } qtab_view_t;

  function automatic logic is_entry(input logic [LINK_W-1:0] v);
    return v < LINK_W'(NUM_ENTRIES);
  endfunction

endpackage

// File: sv/llq_req_if.sv
// ---------------------------------------------------------------------------
// llq_req_if
// Request channel: valid/ready handshake with the action payload.
// ---------------------------------------------------------------------------
interface llq_req_if;
  import llq_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [QID_W-1:0]    queue_id;
  logic [ENTRY_W-1:0]  entry_index;
  logic                source_present;
  logic [QID_W-1:0]    dest_queue;

  modport source (
    output valid, action, queue_id, entry_index, source_present, dest_queue,
    input  ready
  );
  modport sink (
    input  valid, action, queue_id, entry_index, source_present, dest_queue,
    output ready
  );
endinterface

// File: sv/llq_rsp_if.sv
// ---------------------------------------------------------------------------
// llq_rsp_if
// Response channel: valid/ready handshake with the result payload.
// ---------------------------------------------------------------------------
interface llq_rsp_if;
  import llq_pkg::*;

  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] popped_entry;
  logic               popped_valid;
  logic [COUNT_W-1:0] queue_length;

  modport source (
    output valid, popped_entry, popped_valid, queue_length,
    input  ready
  );
  modport sink (
    input  valid, popped_entry, popped_valid, queue_length,
    output ready
  );
endinterface

// File: sv/llq_ram.sv
// ---------------------------------------------------------------------------
// llq_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module llq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: sv/llq_qtab.sv
// ---------------------------------------------------------------------------
// llq_qtab
// Per-queue top, bottom and length with one select port and one shared
// saturating count up/down unit.
// ---------------------------------------------------------------------------
module llq_qtab (
  input  logic               clk,
  input  logic               rst,
  input  llq_pkg::qtab_cmd_t cmd,
  output llq_pkg::qtab_view_t view
);
  import llq_pkg::*;

  logic [LINK_W-1:0]  top    [NUM_QUEUES];
  logic [LINK_W-1:0]  bottom [NUM_QUEUES];
  logic [COUNT_W-1:0] count  [NUM_QUEUES];

  // Read the selected queue and form its saturated neighbors
  always_comb begin
    view.top      = top[cmd.sel];
    view.bottom   = bottom[cmd.sel];
    view.count    = count[cmd.sel];
    view.count_up = (view.count == COUNT_MAX) ? view.count : view.count + 1'b1;
    view.count_dn = (view.count == '0) ? view.count : view.count - 1'b1;
  end

  // Update the selected queue
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        top[i]    <= LINK_NONE;
        bottom[i] <= LINK_NONE;
        count[i]  <= '0;
      end
    end else begin
      if (cmd.top_we) begin
        top[cmd.sel] <= cmd.top_wdata;
      end
      if (cmd.bot_we) begin
        bottom[cmd.sel] <= cmd.bot_wdata;
      end
      if (cmd.cnt_inc) begin
        count[cmd.sel] <= view.count_up;
      end else if (cmd.cnt_dec) begin
        count[cmd.sel] <= view.count_dn;
      end
    end
  end
endmodule

// File: sv/linked_list_queue_manager.sv
// ---------------------------------------------------------------------------
// linked_list_queue_manager
// Doubly linked queues over a shared pool of entry indices.
// ---------------------------------------------------------------------------
// Usage:
//   req carries one request: push an entry at a queue's top, pop the entry
//   at a queue's bottom, or move an entry out of an optional source queue to
//   the bottom of a destination queue. rsp returns exactly one result per
//   request: the popped entry and its flag, and the new length of the queue
//   written last. Malformed requests change nothing and return zeros.
//   One request is in work at a time; req.ready is high only while idle.
//   A push writes the entry's links and the queue top, then links the old top
//   back if any; a pop reads the bottom's previous link, detaches the entry,
//   then clears its next link; a move reads and unlinks the entry from its
//   source queue if present, appends it at the destination bottom, then clears
//   its next link. The steps are set by the previous and next link RAMs, each
//   with one write and one registered read port, stepped by a small sequencer
//   over one shared queue table port. Reset sets all queues empty (ends none,
//   length zero); the link RAMs are not cleared, and the user must see that
//   they are only read once written; the block does not enforce it. The next
//   request waits until the result is loaded, so a stalled rsp blocks it.
// ---------------------------------------------------------------------------
module linked_list_queue_manager (
  input logic     clk,
  input logic     rst,
  llq_req_if.sink   req,
  llq_rsp_if.source rsp
);
  import llq_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_PUSH_W    = 4'd1;
  localparam logic [3:0] S_PUSH_L    = 4'd2;
  localparam logic [3:0] S_POP_RD    = 4'd3;
  localparam logic [3:0] S_POP_W1    = 4'd4;
  localparam logic [3:0] S_POP_W2    = 4'd5;
  localparam logic [3:0] S_MV_RD     = 4'd6;
  localparam logic [3:0] S_MV_UNLINK = 4'd7;
  localparam logic [3:0] S_MV_APPEND = 4'd8;
  localparam logic [3:0] S_MV_TAIL   = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  // Latched request
  logic [QID_W-1:0]   qid;
  logic [QID_W-1:0]   dq;
  logic [ENTRY_W-1:0] ent;
  logic [LINK_W-1:0]  ent_link;
  logic [LINK_W-1:0]  tmp;

  // Result under construction and output slot
  logic [ENTRY_W-1:0] res_popped;
  logic               res_valid;
  logic [COUNT_W-1:0] res_len;
  logic               out_valid;
  logic [ENTRY_W-1:0] out_popped;
  logic               out_pvalid;
  logic [COUNT_W-1:0] out_len;

  // Link RAM ports
  logic               prev_we, prev_re, next_we, next_re;
  logic [ENTRY_W-1:0] prev_waddr, prev_raddr, next_waddr, next_raddr;
  logic [LINK_W-1:0]  prev_wdata, prev_rdata, next_wdata, next_rdata;

  qtab_cmd_t  qcmd;
  qtab_view_t qview;

  logic accept;
  logic q_ok, d_ok, e_ok;
  logic out_load;

  assign accept   = req.valid && req.ready;
  assign ent_link = {1'b0, ent};
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  // Request range checks
  assign q_ok = int'(req.queue_id) < NUM_QUEUES;
  assign d_ok = int'(req.dest_queue) < NUM_QUEUES;
  assign e_ok = int'(req.entry_index) < NUM_ENTRIES;

  llq_qtab u_qtab (
    .clk  (clk),
    .rst  (rst),
    .cmd  (qcmd),
    .view (qview)
  );

  llq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_ENTRIES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (prev_re),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  llq_ram #(.WIDTH(LINK_W), .DEPTH(NUM_ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (next_re),
    .raddr (next_raddr),
    .rdata (next_rdata)
  );

  // Sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DONE;
          case (req.action)
            ACT_PUSH: if (q_ok && e_ok) state_next = S_PUSH_W;
            ACT_POP:  if (q_ok) state_next = S_POP_RD;
            ACT_MOVE: begin
              if (e_ok && d_ok && (!req.source_present || q_ok)) begin
                state_next = req.source_present ? S_MV_RD : S_MV_APPEND;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_PUSH_W:    state_next = is_entry(qview.top) ? S_PUSH_L : S_DONE;
      S_PUSH_L:    state_next = S_DONE;
      S_POP_RD:    state_next = is_entry(qview.bottom) ? S_POP_W1 : S_DONE;
      S_POP_W1:    state_next = S_POP_W2;
      S_POP_W2:    state_next = S_DONE;
      S_MV_RD:     state_next = S_MV_UNLINK;
      S_MV_UNLINK: state_next = S_MV_APPEND;
      S_MV_APPEND: state_next = S_MV_TAIL;
      S_MV_TAIL:   state_next = S_DONE;
      S_DONE:      state_next = out_load ? S_IDLE : S_DONE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Sequencer: link RAM and queue table commands per step
  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = ent;
    prev_wdata = LINK_NONE;
    prev_re    = 1'b0;
    prev_raddr = ent;
    next_we    = 1'b0;
    next_waddr = ent;
    next_wdata = LINK_NONE;
    next_re    = 1'b0;
    next_raddr = ent;
    qcmd           = '0;
    qcmd.sel       = qid;
    qcmd.top_wdata = ent_link;
    qcmd.bot_wdata = ent_link;
    case (state)
      // New entry at top: no previous, next is the old top
      S_PUSH_W: begin
        prev_we     = 1'b1;
        next_we     = 1'b1;
        next_wdata  = qview.top;
        qcmd.top_we = 1'b1;
        qcmd.bot_we = !is_entry(qview.top);
        qcmd.cnt_inc = 1'b1;
      end
      // Old top points back at the new entry
      S_PUSH_L: begin
        prev_we    = 1'b1;
        prev_waddr = tmp[ENTRY_W-1:0];
        prev_wdata = ent_link;
      end
      // Fetch the bottom entry's previous link
      S_POP_RD: begin
        prev_re    = is_entry(qview.bottom);
        prev_raddr = qview.bottom[ENTRY_W-1:0];
      end
      // Detach the bottom entry
      S_POP_W1: begin
        if (is_entry(prev_rdata)) begin
          qcmd.bot_we    = 1'b1;
          qcmd.bot_wdata = prev_rdata;
          next_we        = 1'b1;
          next_waddr     = prev_rdata[ENTRY_W-1:0];
        end else begin
          qcmd.top_we    = 1'b1;
          qcmd.top_wdata = LINK_NONE;
          qcmd.bot_we    = 1'b1;
          qcmd.bot_wdata = LINK_NONE;
        end
        qcmd.cnt_dec = 1'b1;
        prev_we      = 1'b1;
        prev_waddr   = tmp[ENTRY_W-1:0];
      end
      S_POP_W2: begin
        next_we    = 1'b1;
        next_waddr = tmp[ENTRY_W-1:0];
      end
      // Fetch both links of the moved entry
      S_MV_RD: begin
        prev_re = 1'b1;
        next_re = 1'b1;
      end
      // Unlink from the source queue
      S_MV_UNLINK: begin
        if (qview.top == ent_link) begin
          qcmd.top_we    = 1'b1;
          qcmd.top_wdata = next_rdata;
        end
        if (qview.bottom == ent_link) begin
          qcmd.bot_we    = 1'b1;
          qcmd.bot_wdata = prev_rdata;
        end
        if (is_entry(prev_rdata)) begin
          next_we    = 1'b1;
          next_waddr = prev_rdata[ENTRY_W-1:0];
          next_wdata = next_rdata;
        end
        if (is_entry(next_rdata)) begin
          prev_we    = 1'b1;
          prev_waddr = next_rdata[ENTRY_W-1:0];
          prev_wdata = prev_rdata;
        end
        qcmd.cnt_dec = 1'b1;
      end
      // Append at the destination bottom
      S_MV_APPEND: begin
        qcmd.sel   = dq;
        prev_we    = 1'b1;
        prev_wdata = qview.bottom;
        if (is_entry(qview.bottom)) begin
          next_we    = 1'b1;
          next_waddr = qview.bottom[ENTRY_W-1:0];
          next_wdata = ent_link;
        end
        qcmd.bot_we  = 1'b1;
        qcmd.top_we  = !is_entry(qview.top);
        qcmd.cnt_inc = 1'b1;
      end
      S_MV_TAIL: begin
        next_we = 1'b1;
      end
      default: begin
        qcmd.sel = qid;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request, scratch and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          qid        <= req.queue_id;
          dq         <= req.dest_queue;
          ent        <= req.entry_index;
          res_popped <= '0;
          res_valid  <= 1'b0;
          res_len    <= '0;
        end
      end
      S_PUSH_W: begin
        tmp     <= qview.top;
        res_len <= qview.count_up;
      end
      S_POP_RD: begin
        tmp <= qview.bottom;
        if (!is_entry(qview.bottom)) begin
          res_len <= qview.count;
        end
      end
      S_POP_W1: begin
        res_popped <= tmp[ENTRY_W-1:0];
        res_valid  <= 1'b1;
        res_len    <= qview.count_dn;
      end
      S_MV_APPEND: begin
        res_len <= qview.count_up;
      end
      default: begin
        tmp <= tmp;
      end
    endcase
    if (out_load) begin
      out_popped <= res_popped;
      out_pvalid <= res_valid;
      out_len    <= res_len;
    end
  end

  // Ports
  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.popped_entry = out_popped;
  assign rsp.popped_valid = out_pvalid;
  assign rsp.queue_length = out_len;

endmodule

// File: sv/llq_checker.sv
// ---------------------------------------------------------------------------
// llq_checker
// Port-level checks for the linked list queue manager, bound to the top.
// ---------------------------------------------------------------------------
module llq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [llq_pkg::ENTRY_W-1:0] rsp_popped_entry,
  input logic                        rsp_popped_valid,
  input logic [llq_pkg::COUNT_W-1:0] rsp_queue_length
);
  import llq_pkg::*;

  // A stalled result holds its value
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_popped_entry) &&
    $stable(rsp_popped_valid) && $stable(rsp_queue_length))
    else $error("result changed while stalled");

  // One request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // No result appears in the cycle right after a request is taken
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result too early");

  // Popped entry is zero unless a pop returned one
  a_popped_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_popped_valid |-> rsp_popped_entry == '0)
    else $error("popped entry set without pop");

endmodule

bind linked_list_queue_manager llq_checker u_llq_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_popped_entry (rsp.popped_entry),
  .rsp_popped_valid (rsp.popped_valid),
  .rsp_queue_length (rsp.queue_length)
);
